FILE: design/hrp_pkg.sv
`timescale 1ns / 1ps

package hrp_pkg;

    // Parser phases
    localparam logic [2:0] PH_STAT_PRE  = 3'd0;
    localparam logic [2:0] PH_STAT_OWS  = 3'd1;
    localparam logic [2:0] PH_STAT_NUM  = 3'd2;
    localparam logic [2:0] PH_STAT_REST = 3'd3;
    localparam logic [2:0] PH_HDR       = 3'd4;
    localparam logic [2:0] PH_BODY      = 3'd5;
    localparam logic [2:0] PH_DONE      = 3'd6;
    localparam logic [2:0] PH_FAIL      = 3'd7;

    // Number sub-states while parsing the Content-Length value
    localparam logic [3:0] NUM_LEAD   = 4'd0;
    localparam logic [3:0] NUM_SIGN   = 4'd1;
    localparam logic [3:0] NUM_DIGITS = 4'd2;
    localparam logic [3:0] NUM_STOP   = 4'd3;

    localparam logic [3:0] KEY_LEN    = 4'd14;
    localparam logic [9:0] STATUS_MAX = 10'd999;

    // Terminator tracking: CR, CRLF, CRLFCR seen
    localparam logic [1:0] TP_NONE   = 2'd0;
    localparam logic [1:0] TP_CR     = 2'd1;
    localparam logic [1:0] TP_CRLF   = 2'd2;
    localparam logic [1:0] TP_CRLFCR = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_t;

    typedef struct packed {
        logic        body_valid;
        logic [7:0]  body_byte;
        logic        header_done;
        logic [9:0]  status_code;
        logic [31:0] content_length;
        logic        message_done;
        logic        incomplete;
        logic [31:0] bytes_consumed;
    } out_t;

    // Narrow parser state shared between the top level and the update logic
    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] term_prog;
        logic [3:0] match_idx;
        logic       still_match;
        logic       in_value;
        logic       len_found;
        logic       len_neg;
        logic [9:0] status;
    } ctrl_t;

    // Lowercase "content-length"
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        logic r;
        r = (b >= "0") && (b <= "9");
        return r;
    endfunction

endpackage

FILE: design/hrp_next.sv
`timescale 1ns / 1ps

// Per-byte update of the parser state and the result for that byte.
module hrp_next #(
    parameter int LENGTH_BITS = 32
) (
    input  hrp_pkg::in_t             in_data,
    input  hrp_pkg::ctrl_t           ctrl_cur,
    input  logic [LENGTH_BITS-1:0]   len_cur,
    input  logic [LENGTH_BITS-1:0]   rem_cur,
    input  logic [LENGTH_BITS-1:0]   cnt_cur,
    output hrp_pkg::ctrl_t           ctrl_nxt,
    output logic [LENGTH_BITS-1:0]   len_nxt,
    output logic [LENGTH_BITS-1:0]   rem_nxt,
    output logic [LENGTH_BITS-1:0]   cnt_nxt,
    output hrp_pkg::out_t            result
);

    localparam int WIDE_BITS = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

    logic [7:0]               b;
    logic                     eob;
    logic                     b_digit;
    logic [3:0]               digit;
    logic                     b_blank;
    logic                     crlf;
    logic                     term;
    logic                     bvalid;
    logic [LENGTH_BITS+3:0]   len_prod;
    logic [LENGTH_BITS-1:0]   len_digit;
    logic [13:0]              st_prod;
    logic [9:0]               st_digit;
    logic [LENGTH_BITS-1:0]   cnt_inc;
    logic [LENGTH_BITS-1:0]   eff_len;
    logic [WIDE_BITS-1:0]     eff_wide;

    assign b       = in_data.data_byte;
    assign eob     = in_data.end_of_buffer;
    assign b_digit = hrp_pkg::is_digit(b);
    assign digit   = b[3:0];
    assign b_blank = (b == hrp_pkg::CH_SPACE) || (b == hrp_pkg::CH_TAB);

    // length * 10 + digit, saturating on overflow past LENGTH_BITS
    assign len_prod  = ((LENGTH_BITS+4)'(len_cur) << 3) + ((LENGTH_BITS+4)'(len_cur) << 1)
                     + (LENGTH_BITS+4)'(digit);
    assign len_digit = (|len_prod[LENGTH_BITS+3:LENGTH_BITS]) ? '1
                                                               : len_prod[LENGTH_BITS-1:0];

    // status * 10 + digit, clamped to 999
    assign st_prod  = (14'(ctrl_cur.status) << 3) + (14'(ctrl_cur.status) << 1) + 14'(digit);
    assign st_digit = (st_prod > 14'(hrp_pkg::STATUS_MAX)) ? hrp_pkg::STATUS_MAX
                                                           : st_prod[9:0];

    assign cnt_inc = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;

    assign crlf = (b == hrp_pkg::CH_LF) &&
                  ((ctrl_cur.term_prog == hrp_pkg::TP_CR) ||
                   (ctrl_cur.term_prog == hrp_pkg::TP_CRLFCR));
    assign term = (b == hrp_pkg::CH_LF) && (ctrl_cur.term_prog == hrp_pkg::TP_CRLFCR);

    // State update
    always_comb begin
        ctrl_nxt = ctrl_cur;
        len_nxt  = len_cur;
        rem_nxt  = rem_cur;
        cnt_nxt  = cnt_cur;
        bvalid   = 1'b0;

        if (ctrl_cur.phase == hrp_pkg::PH_BODY) begin
            bvalid  = 1'b1;
            cnt_nxt = cnt_inc;
            if (rem_cur != '0) begin
                rem_nxt = rem_cur - 1'b1;
            end
            if (rem_nxt == '0 || eob) begin
                ctrl_nxt.phase = hrp_pkg::PH_DONE;
            end
        end else if (ctrl_cur.phase <= hrp_pkg::PH_HDR) begin
            cnt_nxt = cnt_inc;

            // terminator tracking
            if (b == hrp_pkg::CH_CR) begin
                ctrl_nxt.term_prog = (ctrl_cur.term_prog == hrp_pkg::TP_CRLF) ?
                                     hrp_pkg::TP_CRLFCR : hrp_pkg::TP_CR;
            end else if (crlf) begin
                ctrl_nxt.term_prog = hrp_pkg::TP_CRLF;
            end else begin
                ctrl_nxt.term_prog = hrp_pkg::TP_NONE;
            end

            if (crlf) begin
                // new header line
                ctrl_nxt.phase       = hrp_pkg::PH_HDR;
                ctrl_nxt.in_value    = 1'b0;
                ctrl_nxt.match_idx   = '0;
                ctrl_nxt.still_match = 1'b1;
            end else if (ctrl_cur.phase == hrp_pkg::PH_HDR) begin
                if (!ctrl_cur.in_value) begin
                    // header name: match against content-length
                    if (b == hrp_pkg::CH_COLON) begin
                        ctrl_nxt.in_value = 1'b1;
                        if (ctrl_cur.still_match && ctrl_cur.match_idx == hrp_pkg::KEY_LEN &&
                            !ctrl_cur.len_found) begin
                            ctrl_nxt.len_found   = 1'b1;
                            ctrl_nxt.still_match = 1'b1;
                            ctrl_nxt.len_neg     = 1'b0;
                            len_nxt              = '0;
                        end else begin
                            ctrl_nxt.still_match = 1'b0;
                        end
                        ctrl_nxt.match_idx = hrp_pkg::NUM_LEAD;
                    end else if (ctrl_cur.still_match && ctrl_cur.match_idx < hrp_pkg::KEY_LEN &&
                                 hrp_pkg::to_lower(b) ==
                                 hrp_pkg::key_char(ctrl_cur.match_idx)) begin
                        ctrl_nxt.match_idx = ctrl_cur.match_idx + 4'd1;
                    end else begin
                        ctrl_nxt.still_match = 1'b0;
                    end
                end else if (ctrl_cur.still_match) begin
                    // Content-Length value
                    unique case (ctrl_cur.match_idx) inside
                        hrp_pkg::NUM_LEAD: begin
                            if (b_blank) begin
                                ctrl_nxt.match_idx = hrp_pkg::NUM_LEAD;
                            end else if (b == hrp_pkg::CH_PLUS) begin
                                ctrl_nxt.match_idx = hrp_pkg::NUM_SIGN;
                            end else if (b == hrp_pkg::CH_MINUS) begin
                                ctrl_nxt.len_neg   = 1'b1;
                                ctrl_nxt.match_idx = hrp_pkg::NUM_SIGN;
                            end else if (b_digit) begin
                                len_nxt            = len_digit;
                                ctrl_nxt.match_idx = hrp_pkg::NUM_DIGITS;
                            end else begin
                                ctrl_nxt.match_idx = hrp_pkg::NUM_STOP;
                            end
                        end
                        hrp_pkg::NUM_SIGN, hrp_pkg::NUM_DIGITS: begin
                            if (b_digit) begin
                                len_nxt            = len_digit;
                                ctrl_nxt.match_idx = hrp_pkg::NUM_DIGITS;
                            end else begin
                                ctrl_nxt.match_idx = hrp_pkg::NUM_STOP;
                            end
                        end
                        default: begin
                            ctrl_nxt.match_idx = ctrl_cur.match_idx;
                        end
                    endcase
                end
            end else begin
                // status line
                unique case (ctrl_cur.phase)
                    hrp_pkg::PH_STAT_PRE: begin
                        if (b == hrp_pkg::CH_SPACE) begin
                            ctrl_nxt.phase = hrp_pkg::PH_STAT_OWS;
                        end
                    end
                    hrp_pkg::PH_STAT_OWS: begin
                        if (b_blank) begin
                            ctrl_nxt.phase = hrp_pkg::PH_STAT_OWS;
                        end else if (b_digit) begin
                            ctrl_nxt.status = 10'(digit);
                            ctrl_nxt.phase  = hrp_pkg::PH_STAT_NUM;
                        end else begin
                            ctrl_nxt.phase = hrp_pkg::PH_STAT_REST;
                        end
                    end
                    hrp_pkg::PH_STAT_NUM: begin
                        if (b_digit) begin
                            ctrl_nxt.status = st_digit;
                        end else begin
                            ctrl_nxt.phase = hrp_pkg::PH_STAT_REST;
                        end
                    end
                    default: begin
                        ctrl_nxt.phase = ctrl_cur.phase;
                    end
                endcase
            end

            if (term) begin
                rem_nxt        = (ctrl_nxt.len_found && !ctrl_nxt.len_neg) ? len_nxt : '0;
                ctrl_nxt.phase = (rem_nxt == '0 || eob) ? hrp_pkg::PH_DONE : hrp_pkg::PH_BODY;
            end else if (eob) begin
                ctrl_nxt.phase = hrp_pkg::PH_FAIL;
            end
        end
    end

    // Result for this byte, from the updated state
    assign eff_len  = (ctrl_nxt.len_found && !ctrl_nxt.len_neg) ? len_nxt : '0;
    assign eff_wide = WIDE_BITS'(eff_len);

    always_comb begin
        logic [WIDE_BITS-1:0] cnt_wide;
        cnt_wide              = WIDE_BITS'(cnt_nxt);
        result.body_valid     = bvalid;
        result.body_byte      = bvalid ? b : 8'h00;
        result.header_done    = (ctrl_nxt.phase == hrp_pkg::PH_BODY) ||
                                (ctrl_nxt.phase == hrp_pkg::PH_DONE);
        result.status_code    = ctrl_nxt.status;
        result.content_length = (eff_wide > WIDE_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                       : eff_wide[31:0];
        result.message_done   = (ctrl_nxt.phase == hrp_pkg::PH_DONE);
        result.incomplete     = (ctrl_nxt.phase == hrp_pkg::PH_FAIL);
        result.bytes_consumed = (cnt_wide > WIDE_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                       : cnt_wide[31:0];
    end

endmodule

FILE: design/http_response_header_parser.sv
`timescale 1ns / 1ps

// Streaming HTTP/1.1 response parser, one response byte per item. The parser
// state registers and a single layer of update logic produce the result item,
// which is registered in an output register on acceptance. A new byte is taken
// every cycle while the result side is ready, and also while a result waits,
// as long as the output register is being drained in the same cycle. Each
// byte yields one result item carrying the body byte (when in the body),
// status code, Content-Length and framing flags. Length arithmetic is
// LENGTH_BITS wide and saturates; the 32-bit outputs saturate at 2^32-1.
// Bytes after completion or failure give results that hold their values with
// body_valid low; reset starts a new response.
module http_response_header_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  hrp_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output hrp_pkg::out_t m_data
);

    hrp_pkg::ctrl_t         ctrl_reg;
    hrp_pkg::ctrl_t         ctrl_next;
    logic [LENGTH_BITS-1:0] len_reg;
    logic [LENGTH_BITS-1:0] len_next;
    logic [LENGTH_BITS-1:0] rem_reg;
    logic [LENGTH_BITS-1:0] rem_next;
    logic [LENGTH_BITS-1:0] cnt_reg;
    logic [LENGTH_BITS-1:0] cnt_next;
    hrp_pkg::out_t          result;
    hrp_pkg::out_t          m_data_reg;
    logic                   m_valid_reg;
    logic                   accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    hrp_next #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_next (
        .in_data  (s_data),
        .ctrl_cur (ctrl_reg),
        .len_cur  (len_reg),
        .rem_cur  (rem_reg),
        .cnt_cur  (cnt_reg),
        .ctrl_nxt (ctrl_next),
        .len_nxt  (len_next),
        .rem_nxt  (rem_next),
        .cnt_nxt  (cnt_next),
        .result   (result)
    );

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.phase       <= hrp_pkg::PH_STAT_PRE;
            ctrl_reg.term_prog   <= hrp_pkg::TP_NONE;
            ctrl_reg.match_idx   <= '0;
            ctrl_reg.still_match <= 1'b1;
            ctrl_reg.in_value    <= 1'b0;
            ctrl_reg.len_found   <= 1'b0;
            ctrl_reg.len_neg     <= 1'b0;
            ctrl_reg.status      <= '0;
            len_reg              <= '0;
            rem_reg              <= '0;
            cnt_reg              <= '0;
        end else if (accept) begin
            ctrl_reg <= ctrl_next;
            len_reg  <= len_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

endmodule

FILE: design/hrp_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the response parser
module hrp_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input hrp_pkg::out_t m_data
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // success and failure are exclusive
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.incomplete && m_data.header_done))
        else $error("incomplete with header done");

    // completion implies a finished header
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.message_done |-> m_data.header_done)
        else $error("message done before header");

    // body bytes only after the header terminator
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.body_valid |-> m_data.header_done && !m_data.incomplete)
        else $error("body byte outside body");

    // a free output side never stalls the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled with output ready");

endmodule

bind http_response_header_parser hrp_checker u_hrp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // How the single response of this run ends
    typedef enum int {
        END_IN_HEADER,
        END_ZERO_LENGTH,
        END_FULL_BODY,
        END_CUT_BODY,
        END_AT_TERMINATOR
    } ending_t;

    localparam longint unsigned LEN_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam logic [111:0] LENGTH_NAME = "content-length";

    logic           aclk;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    hrp_pkg::in_t   s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    hrp_pkg::out_t  m_data;

    http_response_header_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Parser state mirrored by the predictor
    logic [2:0]      p_phase;
    logic [1:0]      p_term;
    logic [3:0]      p_idx;
    logic            p_match;
    logic            p_in_value;
    logic            p_found;
    logic            p_neg;
    int              p_status;
    longint unsigned p_len;
    longint unsigned p_remaining;
    longint unsigned p_consumed;

    hrp_pkg::out_t outputs_due[$];
    int            failures   = 0;
    int            items_sent = 0;
    bit            idle_on    = 1'b1;
    ending_t       finish_mode;
    int            body_target;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [7:0] name_char(input logic [3:0] idx);
        return LENGTH_NAME[8*(13 - int'(idx)) +: 8];
    endfunction

    function automatic longint unsigned append_digit(input longint unsigned v,
                                                     input int d);
        if (v > (LEN_MAX - d) / 10) return LEN_MAX;
        return v * 10 + d;
    endfunction

    function automatic longint unsigned count_up(input longint unsigned v);
        return (v >= LEN_MAX) ? LEN_MAX : v + 1;
    endfunction

    function automatic logic [7:0] any_case(input logic [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'd32;
        return c;
    endfunction

    // Random header byte that never completes CR LF CR LF by accident
    function automatic logic [7:0] header_noise();
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        if (p_term == hrp_pkg::TP_CRLFCR && r == hrp_pkg::CH_LF) r = "x";
        return r;
    endfunction

    task automatic clear_parser();
        p_phase     = hrp_pkg::PH_STAT_PRE;
        p_term      = hrp_pkg::TP_NONE;
        p_idx       = hrp_pkg::NUM_LEAD;
        p_match     = 1'b1;
        p_in_value  = 1'b0;
        p_found     = 1'b0;
        p_neg       = 1'b0;
        p_status    = 0;
        p_len       = 0;
        p_remaining = 0;
        p_consumed  = 0;
    endtask

    // Advance the mirrored parser by one byte and queue the result it gives
    task automatic step_parser(input logic [7:0] b, input logic eob);
        hrp_pkg::out_t   res;
        logic [1:0]      prev;
        logic [7:0]      folded;
        bit              bvalid;
        bit              crlf;
        bit              term;
        bit              num;
        int              dval;
        longint unsigned eff;
        bvalid = 1'b0;
        num    = (b >= "0" && b <= "9");
        dval   = int'(b) - 48;
        folded = (b >= "A" && b <= "Z") ? b + 8'd32 : b;

        if (p_phase == hrp_pkg::PH_BODY) begin
            bvalid     = 1'b1;
            p_consumed = count_up(p_consumed);
            if (p_remaining > 0) p_remaining--;
            if (p_remaining == 0 || eob) p_phase = hrp_pkg::PH_DONE;
        end else if (p_phase <= hrp_pkg::PH_HDR) begin
            prev       = p_term;
            crlf       = (b == hrp_pkg::CH_LF) &&
                         (prev == hrp_pkg::TP_CR || prev == hrp_pkg::TP_CRLFCR);
            term       = (b == hrp_pkg::CH_LF) && (prev == hrp_pkg::TP_CRLFCR);
            p_consumed = count_up(p_consumed);
            if (b == hrp_pkg::CH_CR)
                p_term = (prev == hrp_pkg::TP_CRLF) ? hrp_pkg::TP_CRLFCR : hrp_pkg::TP_CR;
            else if (crlf) p_term = hrp_pkg::TP_CRLF;
            else p_term = hrp_pkg::TP_NONE;

            if (crlf) begin
                // new header line
                p_phase    = hrp_pkg::PH_HDR;
                p_in_value = 1'b0;
                p_idx      = hrp_pkg::NUM_LEAD;
                p_match    = 1'b1;
            end else if (p_phase == hrp_pkg::PH_HDR) begin
                if (!p_in_value) begin
                    // header name: case-folded compare against the length key
                    if (b == hrp_pkg::CH_COLON) begin
                        p_in_value = 1'b1;
                        if (p_match && p_idx == hrp_pkg::KEY_LEN && !p_found) begin
                            p_found = 1'b1;
                            p_len   = 0;
                            p_neg   = 1'b0;
                        end else begin
                            p_match = 1'b0;
                        end
                        p_idx = hrp_pkg::NUM_LEAD;
                    end else if (p_match && p_idx < hrp_pkg::KEY_LEN &&
                                 folded == name_char(p_idx)) begin
                        p_idx++;
                    end else begin
                        p_match = 1'b0;
                    end
                end else if (p_match) begin
                    // value of the first length header
                    case (p_idx) inside
                        hrp_pkg::NUM_LEAD: begin
                            if (b != hrp_pkg::CH_SPACE && b != hrp_pkg::CH_TAB) begin
                                if (b == hrp_pkg::CH_PLUS) begin
                                    p_idx = hrp_pkg::NUM_SIGN;
                                end else if (b == hrp_pkg::CH_MINUS) begin
                                    p_neg = 1'b1;
                                    p_idx = hrp_pkg::NUM_SIGN;
                                end else if (num) begin
                                    p_len = append_digit(p_len, dval);
                                    p_idx = hrp_pkg::NUM_DIGITS;
                                end else begin
                                    p_idx = hrp_pkg::NUM_STOP;
                                end
                            end
                        end
                        hrp_pkg::NUM_SIGN, hrp_pkg::NUM_DIGITS: begin
                            if (num) begin
                                p_len = append_digit(p_len, dval);
                                p_idx = hrp_pkg::NUM_DIGITS;
                            end else begin
                                p_idx = hrp_pkg::NUM_STOP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end else begin
                // status line
                case (p_phase)
                    hrp_pkg::PH_STAT_PRE: begin
                        if (b == hrp_pkg::CH_SPACE) p_phase = hrp_pkg::PH_STAT_OWS;
                    end
                    hrp_pkg::PH_STAT_OWS: begin
                        if (b != hrp_pkg::CH_SPACE && b != hrp_pkg::CH_TAB) begin
                            if (num) begin
                                p_status = dval;
                                p_phase  = hrp_pkg::PH_STAT_NUM;
                            end else begin
                                p_phase = hrp_pkg::PH_STAT_REST;
                            end
                        end
                    end
                    hrp_pkg::PH_STAT_NUM: begin
                        if (num) begin
                            p_status = p_status * 10 + dval;
                            if (p_status > int'(hrp_pkg::STATUS_MAX))
                                p_status = int'(hrp_pkg::STATUS_MAX);
                        end else begin
                            p_phase = hrp_pkg::PH_STAT_REST;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            eff = (p_found && !p_neg) ? p_len : 0;
            if (term) begin
                p_remaining = eff;
                p_phase     = (p_remaining == 0 || eob) ? hrp_pkg::PH_DONE : hrp_pkg::PH_BODY;
            end else if (eob) begin
                p_phase = hrp_pkg::PH_FAIL;
            end
        end

        eff                = (p_found && !p_neg) ? p_len : 0;
        res.body_valid     = bvalid;
        res.body_byte      = bvalid ? b : 8'h00;
        res.header_done    = (p_phase == hrp_pkg::PH_BODY || p_phase == hrp_pkg::PH_DONE);
        res.status_code    = 10'(p_status);
        res.content_length = (eff > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(eff);
        res.message_done   = (p_phase == hrp_pkg::PH_DONE);
        res.incomplete     = (p_phase == hrp_pkg::PH_FAIL);
        res.bytes_consumed = (p_consumed > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(p_consumed);
        outputs_due.push_back(res);
    endtask

    // Send one byte, with an occasional idle burst first
    task automatic send_byte(input logic [7:0] b, input logic eob);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, end_of_buffer: eob};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        step_parser(b, eob);
        items_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i], 1'b0);
    endtask

    // Close a line; an empty line would end the header, so pad it
    task automatic end_line();
        if (p_term == hrp_pkg::TP_CRLF) send_byte("x", 1'b0);
        send_byte(hrp_pkg::CH_CR, 1'b0);
        send_byte(hrp_pkg::CH_LF, 1'b0);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (outputs_due.size() != 0) @(posedge aclk);
    endtask

    // Status line: blanks before the code, saturation, missing space, non-digit
    task automatic test_status_line();
        int form;
        form = $urandom_range(0, 3);
        if (form == 2) begin
            send_text("HTTP/1.1-200-OK");
        end else if (form == 3) begin
            send_text("HTTP/1.1 \t?200 OK");
        end else begin
            send_text("HTTP/1.1 ");
            repeat ($urandom_range(0, 3))
                send_byte($urandom_range(0, 1) ? hrp_pkg::CH_SPACE : hrp_pkg::CH_TAB, 1'b0);
            repeat ($urandom_range(1, 5)) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
            send_text(" OK");
        end
        end_line();
    endtask

    // Name matching rules and the first length header, whose value sets the ending
    task automatic test_header_rules();
        int pick;
        send_text("Vary");
        end_line();
        send_text("Content-Lengthy: 12");
        end_line();
        send_text("content-lengt: 12");
        end_line();
        for (int i = 0; i < 14; i++) send_byte(any_case(name_char(4'(i))), 1'b0);
        send_byte(hrp_pkg::CH_COLON, 1'b0);
        case (finish_mode)
            END_ZERO_LENGTH: begin
                pick = $urandom_range(0, 3);
                case (pick)
                    0:       send_text(" -25");
                    1:       send_text("");
                    2:       send_text(" \tabc");
                    default: send_text("+0");
                endcase
            end
            END_FULL_BODY: begin
                body_target = $urandom_range(150, 220);
                send_text($sformatf(" \t+0%0d 7", body_target));
            end
            END_AT_TERMINATOR: send_text($sformatf(" %0d", $urandom_range(1, 99999)));
            default: send_text(" 98765432109876");
        endcase
        end_line();
        // a later length header is ignored
        send_text("Content-Length: 3");
        end_line();
    endtask

    // Random header lines up to a running item count
    task automatic test_random_headers(input int upto);
        int n;
        while (items_sent < upto) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 12))
                        send_byte(any_case(8'("a" + $urandom_range(0, 25))), 1'b0);
                end
                3, 4: begin
                    n = $urandom_range(0, 14);
                    for (int i = 0; i < n; i++) send_byte(any_case(name_char(4'(i))), 1'b0);
                    if ($urandom_range(0, 1) == 1) send_byte("s", 1'b0);
                end
                5: begin
                    for (int i = 0; i < 14; i++) send_byte(any_case(name_char(4'(i))), 1'b0);
                end
                6: begin
                    repeat ($urandom_range(1, 8)) send_byte(header_noise(), 1'b0);
                end
                default: begin
                    // CR LF CR not followed by LF
                    send_byte("x", 1'b0);
                    send_byte(hrp_pkg::CH_CR, 1'b0);
                    send_byte(hrp_pkg::CH_LF, 1'b0);
                    send_byte(hrp_pkg::CH_CR, 1'b0);
                end
            endcase
            if ($urandom_range(0, 7) != 0) send_byte(hrp_pkg::CH_COLON, 1'b0);
            repeat ($urandom_range(0, 10)) begin
                case ($urandom_range(0, 4))
                    0: send_byte($urandom_range(0, 1) ? hrp_pkg::CH_SPACE : hrp_pkg::CH_TAB,
                                 1'b0);
                    1: send_byte($urandom_range(0, 1) ? hrp_pkg::CH_PLUS : hrp_pkg::CH_MINUS,
                                 1'b0);
                    2, 3: send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
                    default: send_byte(header_noise(), 1'b0);
                endcase
            end
            end_line();
        end
    endtask

    // Header end (or a buffer cut inside it) and the body
    task automatic test_header_end_and_body();
        int n;
        drain_results();
        if (finish_mode == END_IN_HEADER) begin
            send_byte(header_noise(), 1'b1);
            return;
        end
        send_byte(hrp_pkg::CH_CR, 1'b0);
        send_byte(hrp_pkg::CH_LF, finish_mode == END_AT_TERMINATOR);
        n = (finish_mode == END_FULL_BODY) ? body_target :
            (finish_mode == END_CUT_BODY) ? $urandom_range(150, 220) : 0;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) idle_on = 1'b0;
            send_byte(8'($urandom_range(0, 255)), finish_mode == END_CUT_BODY && i == n - 1);
        end
    endtask

    // Bytes after completion or failure leave the outputs held
    task automatic test_ignored_tail();
        idle_on = 1'b0;
        repeat (16) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    // Result side: random stall bursts while idling is on
    initial begin : ready_driver
        @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    // Compare each result item with the oldest prediction
    always @(posedge aclk) begin : result_check
        hrp_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outputs_due.size() == 0) begin
                $error("result item with no byte pending");
                failures++;
            end else begin
                want = outputs_due.pop_front();
                check_field("body_valid", 64'(want.body_valid), 64'(m_data.body_valid));
                check_field("body_byte", 64'(want.body_byte), 64'(m_data.body_byte));
                check_field("header_done", 64'(want.header_done), 64'(m_data.header_done));
                check_field("status_code", 64'(want.status_code), 64'(m_data.status_code));
                check_field("content_length", 64'(want.content_length),
                            64'(m_data.content_length));
                check_field("message_done", 64'(want.message_done),
                            64'(m_data.message_done));
                check_field("incomplete", 64'(want.incomplete), 64'(m_data.incomplete));
                check_field("bytes_consumed", 64'(want.bytes_consumed),
                            64'(m_data.bytes_consumed));
            end
        end
    end

    initial begin : run
        finish_mode = ending_t'($urandom_range(0, 4));
        body_target = 0;
        clear_parser();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_status_line();
        test_header_rules();
        test_random_headers((finish_mode == END_FULL_BODY || finish_mode == END_CUT_BODY) ?
                            200 : 400);
        test_header_end_and_body();
        test_ignored_tail();

        drain_results();
        repeat (10) @(posedge aclk);
        if (failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
